// File: rtl/tumbling_window_aggregate_check_defines.svh
// Assertion macros shared by the tumbling window aggregate checker RTL.
`ifndef TUMBLING_WINDOW_AGGREGATE_CHECK_DEFINES_SVH
`define TUMBLING_WINDOW_AGGREGATE_CHECK_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define TWAC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define TWAC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/twac_pkg.sv
// Types, constants and codes of the tumbling window aggregate checker.
package twac_pkg;

  localparam int TS_W                = 62;
  localparam int VAL_W               = 32;
  localparam int SUM_W               = 48;
  localparam int CNT_OUT_W           = 17;
  localparam int MAX_WINDOW_ROWS_DEF = 65536;
  localparam int QUEUE_DEPTH         = 4;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 62;
  localparam int IN_DATA_W           = ((TS_W + VAL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W          = ((TS_W + CNT_OUT_W + SUM_W + 7) / 8) * 8;
  localparam int OUT_USER_W          = 2;

  localparam logic [TS_W-1:0] INTERVAL_RST = TS_W'(1000000);

  typedef enum logic [2:0] {
    AGG_AVG   = 3'd0,
    AGG_SUM   = 3'd1,
    AGG_MIN   = 3'd2,
    AGG_MAX   = 3'd3,
    AGG_COUNT = 3'd4
  } agg_fn_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL = 3'd0,
    CFG_FN       = 3'd1,
    CFG_MIN_EN   = 3'd2,
    CFG_MIN_THR  = 3'd3,
    CFG_MAX_EN   = 3'd4,
    CFG_MAX_THR  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_e;

  typedef struct packed {
    logic [TS_W-1:0]         interval;
    agg_fn_e                 fn;
    logic                    min_en;
    logic signed [SUM_W-1:0] min_thr;
    logic                    max_en;
    logic signed [SUM_W-1:0] max_thr;
  } cfg_t;

  // closed window snapshot, row count travels beside it
  typedef struct packed {
    logic [TS_W-1:0]         start;
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] min_v;
    logic signed [VAL_W-1:0] max_v;
    logic                    partial;
    logic                    eob;
  } win_t;

endpackage

// File: rtl/twac_fifo.sv
// Short register queue between the front and back parts.
`include "tumbling_window_aggregate_check_defines.svh"
module twac_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o,
  output logic             empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `TWAC_ASSERT_IMP(a_no_overflow, push_i, !full_o, "push into full queue")
  `TWAC_ASSERT_IMP(a_no_underflow, pop_i, !empty_o, "pop from empty queue")

endmodule

// File: rtl/twac_front.sv
// Front part: takes rows, tracks the open window, queues closed windows.
`include "tumbling_window_aggregate_check_defines.svh"
module twac_front #(
  parameter int CNT_W           = 17,
  parameter int MAX_WINDOW_ROWS = twac_pkg::MAX_WINDOW_ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [twac_pkg::TS_W-1:0]      interval_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [twac_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           full_i,
  output logic                           push_o,
  output twac_pkg::win_t                 push_win_o,
  output logic [CNT_W-1:0]               push_cnt_o
);
  import twac_pkg::*;

  logic                    open_q;
  win_t                    cur_q;
  logic [CNT_W-1:0]        rows_q;
  logic                    pend_q;
  win_t                    pend_win_q;
  logic [CNT_W-1:0]        pend_cnt_q;

  logic                    row_acc, close, last;
  logic [TS_W-1:0]         ts;
  logic signed [VAL_W-1:0] x;
  logic [TS_W+1:0]         win_end;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  win_t                    nxt, cur_out, nxt_out;
  logic [CNT_W-1:0]        nxt_cnt;

  assign s_axis_tready = !pend_q && !full_i;
  assign row_acc       = s_axis_tvalid && s_axis_tready;
  assign ts            = s_axis_tdata[TS_W-1:0];
  assign x             = signed'(s_axis_tdata[TS_W +: VAL_W]);
  assign last          = s_axis_tlast;
  assign win_end       = {2'b00, cur_q.start} + {2'b00, interval_i};
  assign close         = open_q && ({2'b00, ts} >= win_end);

  always_comb begin
    sum_wide = {cur_q.sum[SUM_W-1], cur_q.sum} + {{(SUM_W + 1 - VAL_W){x[VAL_W-1]}}, x};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end

    nxt         = cur_q;
    nxt.partial = 1'b0;
    nxt.eob     = 1'b0;
    if (!open_q || close) begin
      nxt.start = ts;
      nxt.sum   = {{(SUM_W - VAL_W){x[VAL_W-1]}}, x};
      nxt.min_v = x;
      nxt.max_v = x;
      nxt_cnt   = CNT_W'(1);
    end else begin
      nxt.sum   = sum_sat;
      nxt.min_v = (x < cur_q.min_v) ? x : cur_q.min_v;
      nxt.max_v = (x > cur_q.max_v) ? x : cur_q.max_v;
      nxt_cnt   = (rows_q < CNT_W'(MAX_WINDOW_ROWS)) ? rows_q + 1'b1 : rows_q;
    end

    cur_out         = cur_q;
    cur_out.partial = 1'b0;
    cur_out.eob     = 1'b0;
    nxt_out         = nxt;
    nxt_out.partial = 1'b1;
    nxt_out.eob     = 1'b1;

    if (pend_q) begin
      push_o     = !full_i;
      push_win_o = pend_win_q;
      push_cnt_o = pend_cnt_q;
    end else begin
      push_o     = row_acc && (close || last);
      push_win_o = close ? cur_out : nxt_out;
      push_cnt_o = close ? rows_q : nxt_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= 1'b0;
      cur_q      <= '0;
      rows_q     <= '0;
      pend_q     <= 1'b0;
      pend_win_q <= '0;
      pend_cnt_q <= '0;
    end else begin
      if (pend_q && !full_i) begin
        pend_q <= 1'b0;
      end
      if (row_acc) begin
        if (last) begin
          open_q     <= 1'b0;
          cur_q      <= '0;
          rows_q     <= '0;
          pend_q     <= close;
          pend_win_q <= nxt_out;
          pend_cnt_q <= nxt_cnt;
        end else begin
          open_q <= 1'b1;
          cur_q  <= nxt;
          rows_q <= nxt_cnt;
        end
      end
    end
  end

  `TWAC_ASSERT_IMP(a_open_has_rows, open_q, rows_q != '0, "open window holds no rows")

endmodule

// File: rtl/twac_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
module twac_div #(
  parameter int DVD_W = 48,
  parameter int DIV_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int ITER_W = $clog2(DVD_W);

  logic             run_q, done_q;
  logic [ITER_W-1:0] it_q;
  logic [DVD_W-1:0] quo_q;
  logic [DIV_W-1:0] rem_q, div_q;
  logic [DIV_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};
  assign ge      = (rem_sh >= {1'b0, div_q});
  assign done_o  = done_q;
  assign quot_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        it_q  <= '0;
      end else if (run_q) begin
        it_q <= it_q + 1'b1;
        if (it_q == ITER_W'(DVD_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

endmodule

// File: rtl/twac_back.sv
// Back part: forms the aggregate, checks thresholds, drives the result beat.
`include "tumbling_window_aggregate_check_defines.svh"
module twac_back #(
  parameter int CNT_W = 17
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  twac_pkg::cfg_t                  cfg_i,
  input  logic                            empty_i,
  output logic                            pop_o,
  input  twac_pkg::win_t                  head_win_i,
  input  logic [CNT_W-1:0]                head_cnt_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [twac_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [twac_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic                            m_axis_tlast
);
  import twac_pkg::*;

  bk_state_e               state_q, state_d;
  logic                    load, is_avg, viol;
  logic [TS_W-1:0]         start_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    partial_q, eob_q, neg_q;
  logic signed [SUM_W-1:0] agg_q, agg_sel, agg_div;
  logic [SUM_W-1:0]        mag, quo;
  logic                    div_done;

  logic                      out_valid_q;
  logic [OUT_DATA_W-1:0]     out_data_q;
  logic [OUT_USER_W-1:0]     out_user_q;
  logic                      out_last_q;

  assign load   = (state_q == BK_DONE) && (!out_valid_q || m_axis_tready);
  assign pop_o  = !empty_i && ((state_q == BK_IDLE) || load);
  assign is_avg = (cfg_i.fn == AGG_AVG);
  assign mag    = head_win_i.sum[SUM_W-1] ? (~head_win_i.sum + 1'b1) : head_win_i.sum;
  assign agg_div = neg_q ? signed'(~quo + 1'b1) : signed'(quo);
  assign viol   = (cfg_i.min_en && (agg_q < cfg_i.min_thr)) ||
                  (cfg_i.max_en && (agg_q > cfg_i.max_thr));

  always_comb begin
    case (cfg_i.fn)
      AGG_SUM:   agg_sel = head_win_i.sum;
      AGG_MIN:   agg_sel = {{(SUM_W - VAL_W){head_win_i.min_v[VAL_W-1]}}, head_win_i.min_v};
      AGG_MAX:   agg_sel = {{(SUM_W - VAL_W){head_win_i.max_v[VAL_W-1]}}, head_win_i.max_v};
      AGG_COUNT: agg_sel = SUM_W'(head_cnt_i);
      default:   agg_sel = '0;
    endcase
  end

  twac_div #(
    .DVD_W(SUM_W),
    .DIV_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (pop_o && is_avg),
    .dividend_i(mag),
    .divisor_i (head_cnt_i),
    .done_o    (div_done),
    .quot_o    (quo)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (pop_o) begin
          state_d = is_avg ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        if (div_done) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (pop_o) begin
          state_d = is_avg ? BK_DIV : BK_DONE;
        end else if (load) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      start_q   <= head_win_i.start;
      cnt_q     <= head_cnt_i;
      partial_q <= head_win_i.partial;
      eob_q     <= head_win_i.eob;
      neg_q     <= head_win_i.sum[SUM_W-1];
      agg_q     <= agg_sel;
    end else if ((state_q == BK_DIV) && div_done) begin
      agg_q <= agg_div;
    end
    if (load) begin
      out_data_q <= OUT_DATA_W'({agg_q, CNT_OUT_W'(cnt_q), start_q});
      out_user_q <= {partial_q, viol};
      out_last_q <= eob_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  `TWAC_ASSERT_IMP(a_div_done_in_div, div_done, state_q == BK_DIV, "divider done outside divide")
  `TWAC_ASSERT_NXT(a_load_sets_valid, load, m_axis_tvalid, "loaded result not presented")

endmodule

// File: rtl/tumbling_window_aggregate_check.sv
// Rows in: one per cycle unless the queue is full or a last row that closed a window
// still holds its final window. Sum/min/max/count pass the queue, the aggregate and
// the output registers, one per cycle while the sink is ready. An average waits on
// the one-bit-per-cycle divider, popping nothing; a 4-entry queue buffers windows.
// rst_ni is asynchronous, active low: window state clears, control registers reset.
module tumbling_window_aggregate_check #(
  parameter int MAX_WINDOW_ROWS = twac_pkg::MAX_WINDOW_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [twac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [twac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: timestamp[61:0], sample_value[93:62]; tlast: last_row
  input  logic [twac_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: start_ts[61:0], row_count[78:62], aggregate[126:79]
  output logic [twac_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: violated[0], partial[1]; tlast: end_of_batch
  output logic [twac_pkg::OUT_USER_W-1:0] m_axis_tuser,
  output logic                            m_axis_tlast
);
  import twac_pkg::*;

  localparam int CNT_W = $clog2(MAX_WINDOW_ROWS + 1);
  localparam int Q_W   = $bits(win_t) + CNT_W;

  cfg_t             cfg_q;
  logic             push, pop, full, empty;
  win_t             push_win, head_win;
  logic [CNT_W-1:0] push_cnt, head_cnt;
  logic [Q_W-1:0]   head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval <= INTERVAL_RST;
      cfg_q.fn       <= AGG_SUM;
      cfg_q.min_en   <= 1'b0;
      cfg_q.min_thr  <= '0;
      cfg_q.max_en   <= 1'b0;
      cfg_q.max_thr  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INTERVAL: cfg_q.interval <= cfg_data_i[TS_W-1:0];
        CFG_FN:       cfg_q.fn       <= agg_fn_e'(cfg_data_i[2:0]);
        CFG_MIN_EN:   cfg_q.min_en   <= cfg_data_i[0];
        CFG_MIN_THR:  cfg_q.min_thr  <= signed'(cfg_data_i[SUM_W-1:0]);
        CFG_MAX_EN:   cfg_q.max_en   <= cfg_data_i[0];
        CFG_MAX_THR:  cfg_q.max_thr  <= signed'(cfg_data_i[SUM_W-1:0]);
        default: ;
      endcase
    end
  end

  twac_front #(
    .CNT_W          (CNT_W),
    .MAX_WINDOW_ROWS(MAX_WINDOW_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .interval_i   (cfg_q.interval),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .full_i       (full),
    .push_o       (push),
    .push_win_o   (push_win),
    .push_cnt_o   (push_cnt)
  );

  twac_fifo #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({push_win, push_cnt}),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  assign head_win = win_t'(head[Q_W-1:CNT_W]);
  assign head_cnt = head[CNT_W-1:0];

  twac_back #(
    .CNT_W(CNT_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (empty),
    .pop_o        (pop),
    .head_win_i   (head_win),
    .head_cnt_i   (head_cnt),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// File: test/tb_tumbling_window_aggregate_check.sv
// Self-checking testbench for the tumbling window aggregate checker.
`timescale 1ns / 100ps

module tb_tumbling_window_aggregate_check;
  import twac_pkg::*;

  localparam int          CYCLE_LIMIT  = 2_000_000;
  localparam int          TAIL_CYCLES  = 64;
  localparam longint      SUM_HI       = (longint'(1) <<< 47) - 1;
  localparam longint      SUM_LO       = -SUM_HI - 1;
  localparam logic [61:0] TS_TOP       = '1;
  localparam logic [2:0]  FN_UNDEF     = 3'd5;
  localparam logic [2:0]  IDX_SPARE_LO = 3'd6;
  localparam logic [2:0]  IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [61:0]        start;
    logic [16:0]        rows;
    logic signed [47:0] agg;
    logic               viol;
    logic               part;
    logic               eob;
  } win_res_t;

  typedef enum bit {ST_ROW, ST_CFG} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    logic [2:0]  idx;
    logic [61:0] data;
    logic [61:0] ts;
    logic [31:0] val;
    logic        last;
    bit          chk;
    win_res_t    res;
  } dir_step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;

  tumbling_window_aggregate_check dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // register copies
  logic [61:0] cur_interval = INTERVAL_RST;
  logic [2:0]  cur_fn       = AGG_SUM;
  logic        cur_min_en   = 1'b0;
  longint      cur_min_thr  = 0;
  logic        cur_max_en   = 1'b0;
  longint      cur_max_thr  = 0;

  // open window
  logic               acc_open  = 1'b0;
  logic [61:0]        acc_start = '0;
  longint             acc_rows  = 0;
  longint             acc_sum   = 0;
  logic signed [31:0] acc_min   = '0;
  logic signed [31:0] acc_max   = '0;

  win_res_t    pending_windows[$];
  dir_step_t   dir_tab[$];
  bit          typed_on = 1'b0;
  win_res_t    typed_res;
  int          mism = 0;
  int          cycle_cnt = 0;
  int          src_gap_pct = 17;
  int          sink_stall_pct = 46;
  logic [61:0] ts_cursor = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tumbling_window_aggregate_check regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [61:0] data);
    case (idx)
      CFG_INTERVAL: cur_interval = data;
      CFG_FN:       cur_fn = data[2:0];
      CFG_MIN_EN:   cur_min_en = data[0];
      CFG_MIN_THR:  cur_min_thr = longint'($signed(data[47:0]));
      CFG_MAX_EN:   cur_max_en = data[0];
      CFG_MAX_THR:  cur_max_thr = longint'($signed(data[47:0]));
      default: ;
    endcase
  endfunction

  function automatic void enq_win(win_res_t w);
    pending_windows.insert(pending_windows.size(), w);
  endfunction

  function automatic win_res_t close_window(logic fin);
    win_res_t r;
    longint   a;
    case (cur_fn)
      AGG_AVG:   a = (acc_rows != 0) ? acc_sum / acc_rows : 0;
      AGG_SUM:   a = acc_sum;
      AGG_MIN:   a = longint'(acc_min);
      AGG_MAX:   a = longint'(acc_max);
      AGG_COUNT: a = acc_rows;
      default:   a = 0;
    endcase
    r.start = acc_start;
    r.rows  = acc_rows[16:0];
    r.agg   = a[47:0];
    r.viol  = (cur_min_en && a < cur_min_thr) || (cur_max_en && a > cur_max_thr);
    r.part  = fin;
    r.eob   = fin;
    return r;
  endfunction

  function automatic void open_acc(logic [61:0] ts, logic signed [31:0] v);
    acc_open  = 1'b1;
    acc_start = ts;
    acc_rows  = 1;
    acc_sum   = longint'(v);
    acc_min   = v;
    acc_max   = v;
  endfunction

  function automatic void window_step(logic [61:0] ts, logic signed [31:0] v, logic last);
    longint s;
    if (!acc_open) begin
      open_acc(ts, v);
    end else if ({2'b0, ts} >= {2'b0, acc_start} + {2'b0, cur_interval}) begin
      enq_win(close_window(1'b0));
      open_acc(ts, v);
    end else begin
      s = acc_sum + longint'(v);
      if (s > SUM_HI) s = SUM_HI;
      if (s < SUM_LO) s = SUM_LO;
      acc_sum = s;
      if (acc_rows < MAX_WINDOW_ROWS_DEF) acc_rows++;
      if (v < acc_min) acc_min = v;
      if (v > acc_max) acc_max = v;
    end
    if (last) begin
      enq_win(close_window(1'b1));
      acc_open  = 1'b0;
      acc_start = '0;
      acc_rows  = 0;
      acc_sum   = 0;
      acc_min   = '0;
      acc_max   = '0;
    end
  endfunction

  function automatic string fmt_win(win_res_t w);
    return $sformatf("start=%0d rows=%0d agg=%0d viol=%0b part=%0b eob=%0b",
                     w.start, w.rows, w.agg, w.viol, w.part, w.eob);
  endfunction

  always @(posedge clk_i) begin
    win_res_t got, want;
    if (rst_ni) begin
      if (cfg_we_i) apply_reg(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid && s_axis_tready) begin
        window_step(s_axis_tdata[61:0], s_axis_tdata[93:62], s_axis_tlast);
        if (typed_on) pending_windows[pending_windows.size() - 1] = typed_res;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.start = m_axis_tdata[61:0];
        got.rows  = m_axis_tdata[78:62];
        got.agg   = m_axis_tdata[126:79];
        got.viol  = m_axis_tuser[0];
        got.part  = m_axis_tuser[1];
        got.eob   = m_axis_tlast;
        if (pending_windows.size() == 0) begin
          $display("%0t unexpected beat: expected none, got %s", $time, fmt_win(got));
          mism++;
        end else begin
          want = pending_windows.pop_front();
          if (got.start !== want.start || got.rows !== want.rows || got.agg !== want.agg ||
              got.viol !== want.viol || got.part !== want.part || got.eob !== want.eob) begin
            $display("%0t window mismatch: expected %s, got %s",
                     $time, fmt_win(want), fmt_win(got));
            mism++;
          end
        end
      end
    end
  end

  always @(negedge clk_i) m_axis_tready = ($urandom_range(99) >= sink_stall_pct);

  task automatic send_row(logic [61:0] ts, logic [31:0] v, logic last, bit chk,
                          win_res_t res);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {2'b0, v, ts};
    s_axis_tlast  = last;
    typed_on      = chk;
    typed_res     = res;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    typed_on = 1'b0;
  endtask

  task automatic drain_windows(int tail);
    s_axis_tvalid = 1'b0;
    while (pending_windows.size() != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [61:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  function automatic win_res_t final_win(logic [61:0] start, int rows, longint agg, logic viol);
    return '{start: start, rows: 17'(rows), agg: agg[47:0], viol: viol, part: 1'b1, eob: 1'b1};
  endfunction

  function automatic void tab_row(logic [61:0] ts, logic [31:0] v, logic last, bit chk,
                                  win_res_t res);
    dir_step_t st;
    st = '{kind: ST_ROW, idx: '0, data: '0, ts: ts, val: v, last: last,
           chk: chk, res: res};
    dir_tab.insert(dir_tab.size(), st);
  endfunction

  function automatic void tab_cfg(logic [2:0] idx, logic [61:0] data);
    dir_step_t st;
    st = '{kind: ST_CFG, idx: idx, data: data, ts: '0, val: '0, last: 1'b0,
           chk: 1'b0, res: '0};
    dir_tab.insert(dir_tab.size(), st);
  endfunction

  function automatic logic [47:0] pick_thr();
    logic [63:0] r;
    r = rand64();
    case ($urandom_range(4))
      0:       return 48'h8000_0000_0000;
      1:       return 48'h7FFF_FFFF_FFFF;
      2:       return 48'(longint'($urandom_range(200)) - 100);
      3:       return 48'(longint'($signed(r[31:0])));
      default: return r[47:0];
    endcase
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return 32'($urandom_range(2000)) - 32'd1000;
    endcase
  endfunction

  // mostly rows inside the window, some that close it, a few backwards or anywhere
  function automatic logic [61:0] next_ts();
    logic [63:0] ivl, cur, nxt;
    ivl = {2'b0, cur_interval};
    cur = {2'b0, ts_cursor};
    case ($urandom_range(19))
      0:             nxt = {2'b0, rand64() & 64'h3FFF_FFFF_FFFF_FFFF};
      1:             nxt = cur - (rand64() % (cur + 1));
      2, 3, 4, 5, 6: nxt = cur + ivl + (rand64() % (ivl / 4 + 1));
      default:       nxt = cur + (rand64() % (ivl / 3 + 1));
    endcase
    if (nxt > {2'b0, TS_TOP}) nxt = 64'($urandom_range(1000));
    ts_cursor = nxt[61:0];
    return ts_cursor;
  endfunction

  task automatic random_setup(int ph);
    logic [61:0] ivl;
    logic [63:0] r;
    r = rand64();
    case ((ph < 6) ? ph : int'($urandom_range(5)))
      0:       ivl = TS_TOP;
      1:       ivl = '0;
      2:       ivl = 62'd1;
      3:       ivl = 62'($urandom_range(64, 2));
      4:       ivl = INTERVAL_RST;
      default: ivl = r[61:0];
    endcase
    write_reg(CFG_INTERVAL, ivl);
    write_reg(CFG_FN, 62'((ph < 8) ? ph : int'($urandom_range(7))));
    write_reg(CFG_MIN_EN, 62'($urandom_range(1)));
    write_reg(CFG_MIN_THR, {14'b0, pick_thr()});
    write_reg(CFG_MAX_EN, 62'($urandom_range(1)));
    write_reg(CFG_MAX_THR, {14'b0, pick_thr()});
  endtask

  initial begin
    int ph, k;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;

    tab_row(62'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, final_win(62'd0, 1, 64'sd2147483647, 1'b0));
    tab_row(TS_TOP, 32'h8000_0000, 1'b1, 1'b1, final_win(TS_TOP, 1, -64'sd2147483648, 1'b0));
    tab_row(62'd100, 32'd5, 1'b0, 1'b0, '0);
    tab_row(62'd200, -32'sd7, 1'b0, 1'b0, '0);
    tab_row(62'd1000100, 32'd3, 1'b0, 1'b0, '0);
    tab_row(62'd50, 32'd9, 1'b0, 1'b0, '0);           // timestamp goes backwards
    tab_row(62'd1000101, 32'd1, 1'b1, 1'b0, '0);
    tab_cfg(CFG_FN, 62'(AGG_AVG));
    tab_row(62'd0, -32'sd7, 1'b0, 1'b0, '0);
    tab_row(62'd1, 32'd2, 1'b1, 1'b1, final_win(62'd0, 2, -2, 1'b0));
    tab_cfg(CFG_FN, 62'(AGG_MIN));
    tab_row(62'd3, 32'd4, 1'b0, 1'b0, '0);
    tab_row(62'd4, -32'sd9, 1'b0, 1'b0, '0);
    tab_row(62'd5, 32'd1, 1'b1, 1'b0, '0);
    tab_cfg(CFG_FN, 62'(AGG_MAX));
    tab_row(62'd6, 32'd4, 1'b0, 1'b0, '0);
    tab_row(62'd7, -32'sd1, 1'b1, 1'b1, final_win(62'd6, 2, 4, 1'b0));
    tab_cfg(CFG_FN, 62'(AGG_COUNT));
    tab_cfg(CFG_MIN_EN, 62'd1);
    tab_cfg(CFG_MIN_THR, 62'd3);
    tab_row(62'd8, 32'd0, 1'b0, 1'b0, '0);
    tab_row(62'd9, 32'd0, 1'b1, 1'b1, final_win(62'd8, 2, 2, 1'b1));
    tab_cfg(CFG_FN, 62'(FN_UNDEF));
    tab_cfg(CFG_MAX_EN, 62'd1);
    tab_cfg(CFG_MAX_THR, {14'b0, 48'hFFFF_FFFF_FFFF});
    tab_row(62'd10, 32'd77, 1'b1, 1'b1, final_win(62'd10, 1, 0, 1'b1));
    tab_cfg(CFG_MIN_THR, {14'b0, 48'h8000_0000_0000});
    tab_cfg(CFG_MAX_THR, {14'b0, 48'h7FFF_FFFF_FFFF});
    tab_cfg(CFG_FN, 62'(AGG_SUM));
    tab_row(62'd11, 32'h8000_0000, 1'b1, 1'b1,
            final_win(62'd11, 1, -64'sd2147483648, 1'b0));
    tab_cfg(CFG_INTERVAL, 62'd0);
    tab_row(62'd20, 32'd1, 1'b0, 1'b0, '0);
    tab_row(62'd20, 32'd2, 1'b0, 1'b0, '0);
    tab_row(62'd19, 32'd3, 1'b0, 1'b0, '0);
    tab_row(62'd21, 32'd4, 1'b1, 1'b0, '0);           // last row closes a window too
    tab_cfg(IDX_SPARE_LO, '1);
    tab_cfg(IDX_SPARE_HI, '1);
    tab_row(62'd22, 32'd5, 1'b1, 1'b0, '0);
    tab_cfg(CFG_INTERVAL, TS_TOP);
    tab_row(62'd0, 32'd1, 1'b0, 1'b0, '0);
    tab_row(TS_TOP, 32'd2, 1'b1, 1'b0, '0);

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ST_CFG) begin
        drain_windows(TAIL_CYCLES);
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_row(dir_tab[i].ts, dir_tab[i].val, dir_tab[i].last, dir_tab[i].chk,
                 dir_tab[i].res);
      end
    end

    for (ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        src_gap_pct    = 46;
        sink_stall_pct = 17;
      end
      if (ph == 8) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      drain_windows(TAIL_CYCLES);
      random_setup(ph);
      for (k = 0; k < 88; k++) begin
        if ($urandom_range(63) == 0) drain_windows(0);
        send_row(next_ts(), pick_val(), $urandom_range(11) == 0, 1'b0, '0);
      end
    end

    drain_windows(TAIL_CYCLES);
    if (mism == 0 && pending_windows.size() == 0) begin
      $display("tumbling_window_aggregate_check regression: pass");
    end else begin
      $display("tumbling_window_aggregate_check regression: fail");
    end
    $finish;
  end

endmodule
